// ----- hdl/tapg_pkg.sv -----
package tapg_pkg;

    localparam int MUL_BW        = 16;
    localparam int FRAC_BITS     = 15;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam int STEP_BITS     = 32;

    localparam logic [15:0] Q_ONE   = 16'd32768;
    localparam logic [15:0] POLY_C1 = 16'd2320;
    localparam logic [15:0] POLY_C2 = 16'd21024;
    localparam logic [15:0] POLY_C3 = 16'd51472;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DEPTH      = 2'd0,
        CFG_PHASE_STEP = 2'd1,
        CFG_AUTO_PAN   = 2'd2
    } cfg_idx_t;

endpackage

// ----- hdl/tremolo_autopan_gain_core.sv -----
// each accepted sample pair runs through all its products before the result is registered
// for m_tvalid; s_tready stays low, so no new pair is taken until that result is loaded
// seven products (four for the sine polynomial, one for the gain, two for the
// samples) share one bit-serial multiplier, one product at a time
// reset: synchronous active-low aresetn clears lfo phase, depth, step, auto-pan
// and all handshake state; the block takes beats right after reset
module tremolo_autopan_gain_core #(
    parameter int SAMPLE_BITS     = 24,
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // left_in, right_in
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]            s_tdata,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // left_out, right_out
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]            m_tdata,
    input  logic                                          cfg_valid,
    output logic                                          cfg_ready,
    input  logic [tapg_pkg::CFG_IDX_BITS-1:0]             cfg_index,
    input  logic [tapg_pkg::CFG_DATA_BITS-1:0]            cfg_data
);
    import tapg_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int TB  = SINE_TABLE_BITS;
    localparam int DW  = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int AW  = (SAMPLE_BITS > 17) ? SAMPLE_BITS : 17;
    localparam int PW  = AW + MUL_BW;
    localparam int GW  = 34;
    localparam int PAD = DW - 2*SB;

    typedef enum logic [1:0] {ST_IDLE, ST_START, ST_WAIT, ST_OUT} state_t;
    typedef enum logic [2:0] {
        OP_X2, OP_T1, OP_T, OP_Y, OP_GAIN, OP_LEFT, OP_RIGHT
    } mul_op_t;

    state_t  state_reg;
    mul_op_t op_reg;

    logic [15:0]            depth_reg;
    logic [STEP_BITS-1:0]   step_reg;
    logic                   auto_pan_reg;
    logic [PHASE_BITS-1:0]  phase_reg;

    logic [1:0]             quad_reg;
    logic [15:0]            x_reg;
    logic [15:0]            x2_reg;
    logic [15:0]            t_reg;
    logic signed [16:0]     s_reg;
    logic [15:0]            gl_reg;
    logic [15:0]            gr_reg;
    logic signed [AW-1:0]   left_reg;
    logic signed [AW-1:0]   right_reg;
    logic [SB-1:0]          lres_reg;
    logic [SB-1:0]          rres_reg;
    logic                   m_tvalid_reg;
    logic [DW-1:0]          m_tdata_reg;

    logic [TB-1:0]          idx;
    logic [15:0]            x_raw;
    logic [15:0]            d;
    logic                   in_beat;
    logic                   mul_start;
    logic                   mul_done;
    logic signed [AW-1:0]   mul_a;
    logic [MUL_BW-1:0]      mul_b;
    logic signed [PW-1:0]   mul_prod;
    logic [15:0]            prod_frac;
    logic [15:0]            y_clamp;
    logic [GW-1:0]          g30;
    logic [16:0]            gr_calc;

    assign idx       = phase_reg[PHASE_BITS-1 -: TB];
    assign x_raw     = 16'({idx[TB-3:0], {(17-TB){1'b0}}});
    assign d         = (depth_reg > Q_ONE) ? Q_ONE : depth_reg;
    assign in_beat   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign mul_start = (state_reg == ST_START);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign prod_frac = mul_prod[FRAC_BITS +: 16];
    assign y_clamp   = (prod_frac > Q_ONE) ? Q_ONE : prod_frac;
    assign g30       = (GW'(1) << 31) - (GW'(d) << FRAC_BITS) - GW'(mul_prod);
    assign gr_calc   = 17'(65536) - 17'(d) - 17'(g30[31:16]);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (op_reg)
            OP_X2: begin
                mul_a = AW'($signed({1'b0, x_reg}));
                mul_b = x_reg;
            end
            OP_T1: begin
                mul_a = AW'($signed({1'b0, x2_reg}));
                mul_b = POLY_C1;
            end
            OP_T: begin
                mul_a = AW'($signed({1'b0, x2_reg}));
                mul_b = t_reg;
            end
            OP_Y: begin
                mul_a = AW'($signed({1'b0, x_reg}));
                mul_b = t_reg;
            end
            OP_GAIN: begin
                mul_a = AW'(s_reg);
                mul_b = d;
            end
            OP_LEFT: begin
                mul_a = left_reg;
                mul_b = gl_reg;
            end
            OP_RIGHT: begin
                mul_a = right_reg;
                mul_b = gr_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    tapg_mul_serial #(
        .A_BITS (AW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_X2;
            depth_reg    <= '0;
            step_reg     <= '0;
            auto_pan_reg <= 1'b0;
            phase_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_DEPTH:      depth_reg    <= cfg_data[15:0];
                    CFG_PHASE_STEP: step_reg     <= cfg_data[STEP_BITS-1:0];
                    CFG_AUTO_PAN:   auto_pan_reg <= cfg_data[0];
                    default: ;
                endcase
            end

            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_beat) begin
                        left_reg  <= AW'($signed(s_tdata[SB-1:0]));
                        right_reg <= AW'($signed(s_tdata[2*SB-1:SB]));
                        quad_reg  <= idx[TB-1 -: 2];
                        x_reg     <= idx[TB-2] ? (Q_ONE - x_raw) : x_raw;
                        phase_reg <= phase_reg + PHASE_BITS'(step_reg);
                        op_reg    <= OP_X2;
                        state_reg <= ST_START;
                    end
                end
                ST_START: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (mul_done) begin
                        state_reg <= ST_START;
                        unique case (op_reg)
                            OP_X2: begin
                                x2_reg <= prod_frac;
                                op_reg <= OP_T1;
                            end
                            OP_T1: begin
                                t_reg  <= POLY_C2 - prod_frac;
                                op_reg <= OP_T;
                            end
                            OP_T: begin
                                t_reg  <= POLY_C3 - prod_frac;
                                op_reg <= OP_Y;
                            end
                            OP_Y: begin
                                s_reg  <= quad_reg[1] ? -$signed({1'b0, y_clamp})
                                                      : $signed({1'b0, y_clamp});
                                op_reg <= OP_GAIN;
                            end
                            OP_GAIN: begin
                                gl_reg <= g30[31:16];
                                gr_reg <= auto_pan_reg ? gr_calc[15:0] : g30[31:16];
                                op_reg <= OP_LEFT;
                            end
                            OP_LEFT: begin
                                lres_reg <= mul_prod[FRAC_BITS +: SB];
                                op_reg   <= OP_RIGHT;
                            end
                            OP_RIGHT: begin
                                rres_reg  <= mul_prod[FRAC_BITS +: SB];
                                state_reg <= ST_OUT;
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {{PAD{1'b0}}, rres_reg, lres_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> !s_tready)
        else $error("input taken while a pair is in work");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_WAIT))
        else $error("product finished outside the wait state");

    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |-> (gl_reg <= Q_ONE && gr_reg <= Q_ONE))
        else $error("gain above unity");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_tvalid && !m_tready) |=> (state_reg == ST_OUT))
        else $error("result dropped while output stalled");

endmodule

// ----- hdl/tapg_mul_serial.sv -----
module tapg_mul_serial #(
    parameter int A_BITS = 24
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      start,
    input  logic signed [A_BITS-1:0]                  a_in,
    input  logic [tapg_pkg::MUL_BW-1:0]               b_in,
    output logic                                      done,
    output logic signed [A_BITS+tapg_pkg::MUL_BW-1:0] product
);
    import tapg_pkg::*;

    localparam int P_BITS   = A_BITS + MUL_BW;
    localparam int CNT_BITS = $clog2(MUL_BW);

    logic signed [P_BITS-1:0] acc_reg;
    logic signed [P_BITS-1:0] a_sh_reg;
    logic [MUL_BW-1:0]        b_reg;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;

    // one multiplier bit per cycle, lsb first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(MUL_BW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg  <= '0;
            a_sh_reg <= P_BITS'(a_in);
            b_reg    <= b_in;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_reg <= acc_reg + a_sh_reg;
            end
            a_sh_reg <= a_sh_reg <<< 1;
            b_reg    <= b_reg >> 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- sim/tremolo_autopan_gain_core_tb.sv -----
`timescale 1ns / 100ps

module tremolo_autopan_gain_core_tb;
    import tapg_pkg::*;

    localparam int SAMPLE_W = 24;
    localparam int BEAT_W = ((2*SAMPLE_W+7)/8)*8;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_PAIRS = 1500;
    localparam int PHASE_DRAIN = 16;
    localparam int FINAL_DRAIN = 140;
    localparam logic [23:0] SMP_MAX = 24'h7FFFFF;
    localparam logic [23:0] SMP_MIN = 24'h800000;
    localparam logic [15:0] UNITY = 16'd32768;

    class tremolo_gain_checker;
        logic [15:0] depth;
        logic [31:0] step;
        bit auto_pan;
        logic [31:0] lfo_phase;
        logic [BEAT_W-1:0] expected_pairs[$];
        int errors;
        int results;

        function new();
            depth = '0;
            step = '0;
            auto_pan = 1'b0;
            lfo_phase = '0;
            errors = 0;
            results = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_DEPTH: depth = data[15:0];
                CFG_PHASE_STEP: step = data;
                CFG_AUTO_PAN: auto_pan = data[0];
                default: ;
            endcase
        endfunction

        static function int sine_q15(logic [9:0] k);
            logic [31:0] x, x2, t, y;
            x = {17'd0, k[7:0], 7'd0};
            if (k[8])
                x = 32'd32768 - x;
            x2 = (x * x) >> 15;
            t = 32'd21024 - ((32'd2320 * x2) >> 15);
            t = 32'd51472 - ((t * x2) >> 15);
            y = (t * x) >> 15;
            if (y > 32'd32768)
                y = 32'd32768;
            return k[9] ? -int'(y) : int'(y);
        endfunction

        static function logic [SAMPLE_W-1:0] scale_sample(longint smp, longint gain);
            longint p;
            p = (smp * gain) >>> 15;
            return p[SAMPLE_W-1:0];
        endfunction

        function void note_input(logic [BEAT_W-1:0] beat);
            longint l, r, s, dd, g30, gl, gr;
            logic [SAMPLE_W-1:0] lo, ro;
            l = $signed(beat[SAMPLE_W-1:0]);
            r = $signed(beat[2*SAMPLE_W-1:SAMPLE_W]);
            dd = (depth > UNITY) ? longint'(UNITY) : longint'(depth);
            s = sine_q15(lfo_phase[31:22]);
            g30 = (longint'(1) <<< 31) - (dd <<< 15) - dd * s;
            gl = g30 >>> 16;
            gr = auto_pan ? 65536 - dd - gl : gl;
            lo = scale_sample(l, gl);
            ro = scale_sample(r, gr);
            expected_pairs.push_back({{(BEAT_W-2*SAMPLE_W){1'b0}}, ro, lo});
            lfo_phase = lfo_phase + step;
        endfunction

        function void check_result(logic [BEAT_W-1:0] beat);
            logic [BEAT_W-1:0] want;
            results++;
            if (expected_pairs.size() == 0) begin
                $error("output beat with nothing pending: %h", beat);
                errors++;
                return;
            end
            want = expected_pairs.pop_front();
            if (beat[SAMPLE_W-1:0] !== want[SAMPLE_W-1:0]) begin
                $error("left_out expected %h actual %h",
                       want[SAMPLE_W-1:0], beat[SAMPLE_W-1:0]);
                errors++;
            end
            if (beat[2*SAMPLE_W-1:SAMPLE_W] !== want[2*SAMPLE_W-1:SAMPLE_W]) begin
                $error("right_out expected %h actual %h",
                       want[2*SAMPLE_W-1:SAMPLE_W], beat[2*SAMPLE_W-1:SAMPLE_W]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [BEAT_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [BEAT_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    tremolo_gain_checker gain_chk = new();
    int cycle_count = 0;
    int pairs_in = 0;
    int reg_writes = 0;
    int settings_run = 0;
    int burst_left = 0;
    int gap_max = 0;
    int stall_left = 0;
    bit stall_on = 1'b0;

    tremolo_autopan_gain_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats pending", cycle_count,
                     gain_chk.pending());
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                gain_chk.note_input(s_tdata);
                pairs_in++;
            end
            if (cfg_valid && cfg_ready) begin
                gain_chk.write_reg(cfg_index, cfg_data);
                reg_writes++;
            end
            if (m_tvalid && m_tready)
                gain_chk.check_result(m_tdata);
        end
    end

    // receiver backpressure
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (stall_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 40);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_pair(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {{(BEAT_W-2*SAMPLE_W){1'b0}}, r, l};
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(0, gap_max);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(0, 12);
        end
    endtask

    task automatic drain(input int extra);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (gain_chk.pending() != 0)
            @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [15:0] depth, input logic [31:0] step,
                                 input bit pan);
        write_reg(CFG_DEPTH, {16'd0, depth});
        write_reg(CFG_PHASE_STEP, step);
        write_reg(CFG_AUTO_PAN, {31'd0, pan});
        settings_run++;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 7))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return SAMPLE_W'($signed($urandom_range(0, 511)) - 256);
            default: return raw[SAMPLE_W-1:0];
        endcase
    endfunction

    function automatic logic [15:0] pick_depth();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return UNITY;
            2: return raw[15:0];
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'h8000_0000;
            2: return $urandom();
            3: return $urandom_range(0, 1 << 22);
            default: return $urandom_range(0, 1 << 27);
        endcase
    endfunction

    initial begin
        int count;
        int sent;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // unity gain at reset values
        send_pair(SMP_MAX, SMP_MIN);
        send_pair(SMP_MIN, SMP_MAX);
        send_pair(24'd0, 24'hFFFFFF);
        send_pair(24'hFFFFFF, 24'd1);
        drain(PHASE_DRAIN);

        // full depth, quarter-cycle steps, mirrored gain
        apply_setting(UNITY, 32'h4000_0000, 1'b1);
        send_pair(SMP_MAX, SMP_MAX);
        send_pair(SMP_MIN, SMP_MIN);
        send_pair(SMP_MAX, SMP_MIN);
        send_pair(SMP_MIN, SMP_MAX);
        send_pair(24'hFFFFFF, 24'd1);
        send_pair(24'd1, 24'hFFFFFF);
        send_pair(24'h555555, 24'hAAAAAA);
        send_pair(24'hAAAAAA, 24'h555555);
        drain(PHASE_DRAIN);

        // ignored index, saturated depth, half-cycle step
        write_reg(CFG_SPARE, 32'hFFFF_FFFF);
        apply_setting(16'hFFFF, 32'h8000_0000, 1'b0);
        send_pair(SMP_MAX, SMP_MIN);
        send_pair(SMP_MIN, SMP_MAX);
        send_pair(24'hFFFFFF, 24'hFFFFFF);
        drain(PHASE_DRAIN);

        // all-ones step wraps the phase backward
        apply_setting(16'h8001, 32'hFFFF_FFFF, 1'b1);
        send_pair(SMP_MAX, SMP_MIN);
        send_pair(SMP_MIN, SMP_MAX);
        send_pair(24'h123456, 24'hEDCBA9);
        drain(PHASE_DRAIN);

        sent = 0;
        while (sent < RANDOM_PAIRS) begin
            if ($urandom_range(0, 5) == 0)
                write_reg(CFG_SPARE, $urandom());
            apply_setting(pick_depth(), pick_step(), 1'($urandom_range(0, 1)));
            gap_max <= ($urandom_range(0, 2) == 0) ? 0 : 20;
            stall_on <= ($urandom_range(0, 2) != 0);
            count = $urandom_range(40, 160);
            repeat (count) begin
                send_pair(pick_sample(), pick_sample());
                sent++;
            end
            drain(PHASE_DRAIN);
        end

        drain(FINAL_DRAIN);
        $display("%0d sample pairs checked over %0d gain settings, %0d register writes",
                 gain_chk.results, settings_run, reg_writes);
        $display("includes full and saturated depth, phase wrap, pan on/off, unused index");
        if (gain_chk.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
